// ----- rtl/core/bfu_pkg.sv -----
package bfu_pkg;

  localparam int NUM_BOIDS_DEF = 64;
  localparam int GROUPS_DEF    = 4;

  localparam int IDXW = 6;
  localparam int FW   = 24;

  localparam int IN_DW  = 104;
  localparam int OUT_DW = 96;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 13;

  localparam logic [CFG_AW-1:0] REG_SEP_DIV = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ALI_DIV = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COH_DIV = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MAX_SPD = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PERC_R  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CLOSE_R = 3'd5;
  localparam logic [CFG_AW-1:0] REG_WORLD_W = 3'd6;
  localparam logic [CFG_AW-1:0] REG_WORLD_H = 3'd7;

  localparam logic [9:0]  RST_SEP_DIV = 10'd16;
  localparam logic [9:0]  RST_ALI_DIV = 10'd250;
  localparam logic [9:0]  RST_COH_DIV = 10'd250;
  localparam logic [7:0]  RST_MAX_SPD = 8'd5;
  localparam logic [10:0] RST_PERC_R  = 11'd100;
  localparam logic [10:0] RST_CLOSE_R = 11'd20;
  localparam logic [12:0] RST_WORLD_W = 13'd1280;
  localparam logic [12:0] RST_WORLD_H = 13'd720;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam int DIV_NW = 41;
  localparam int DIV_DW = 25;
  localparam int SQ_RW  = 24;
  localparam int SQ_SW  = 48;

  typedef enum logic [3:0] {
    OP_SEP_X, OP_SEP_Y, OP_ALI_X, OP_ALI_Y, OP_AVG_X,
    OP_AVG_Y, OP_COH_X, OP_COH_Y, OP_CAP_X, OP_CAP_Y
  } div_op_t;

  typedef enum logic [1:0] {RES_ZERO, RES_LOAD, RES_UPD} res_sel_t;

  typedef struct packed {
    logic            cap_in;
    logic            load_wr;
    logic            upd_wr;
    logic            self_rd;
    logic            self_cap;
    logic            scan_rd;
    logic [IDXW-1:0] scan_k;
    logic            prep;
    logic            div_start;
    div_op_t         div_op;
    logic            vel_upd;
    logic            mul;
    logic            cmp;
    logic            sqrt_start;
    logic            wrap;
    logic            out_load;
    res_sel_t        res_sel;
  } bfu_cmd_t;

  typedef struct packed {
    logic is_update;
    logic in_range;
    logic scan_busy;
    logic any_close;
    logic any_near;
    logic div_busy;
    logic div_done;
    logic sqrt_done;
    logic need_cap;
  } bfu_sts_t;

endpackage

// ----- rtl/core/bfu_ram.sv -----
module bfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bfu_div.sv -----
module bfu_div #(
  parameter int NW = 41,
  parameter int DW = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic                 busy,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  mag;
  logic [DW-1:0]  rem;
  logic [DW-1:0]  dd;
  logic           neg;
  logic [CNW-1:0] cnt;
  logic [DW:0]    trial;
  logic           fits;

  assign trial = {rem, mag[NW-1]};
  assign fits  = trial >= {1'b0, dd};
  assign quo   = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(NW);
        mag  <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
        neg  <= num[NW-1];
        rem  <= '0;
        dd   <= den;
      end else if (busy) begin
        rem <= fits ? DW'(trial - {1'b0, dd}) : trial[DW-1:0];
        mag <= {mag[NW-2:0], fits};
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/bfu_sqrt.sv -----
module bfu_sqrt #(
  parameter int RW = 24,
  localparam int SW = 2 * RW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SW-1:0] s,
  output logic          done,
  output logic [RW-1:0] root
);

  logic [SW-1:0] sv;
  logic [RW-1:0] bitpos;
  logic          busy;
  logic [RW-1:0] cand;
  logic [SW-1:0] prod;

  assign cand = root | bitpos;
  assign prod = SW'(cand) * SW'(cand);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        sv     <= s;
        root   <= '0;
        bitpos <= {1'b1, {(RW-1){1'b0}}};
      end else if (busy) begin
        if (prod <= sv) begin
          root <= cand;
        end
        bitpos <= bitpos >> 1;
        if (bitpos[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/bfu_datapath.sv -----
module bfu_datapath #(
  parameter int NUM_BOIDS = 64,
  parameter int GROUPS    = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfu_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [bfu_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          in_cmd,
  input  logic [bfu_pkg::IDXW-1:0]      in_index,
  input  logic signed [bfu_pkg::FW-1:0] in_pos_x,
  input  logic signed [bfu_pkg::FW-1:0] in_pos_y,
  input  logic signed [bfu_pkg::FW-1:0] in_vel_x,
  input  logic signed [bfu_pkg::FW-1:0] in_vel_y,
  input  bfu_pkg::bfu_cmd_t             cmd,
  output bfu_pkg::bfu_sts_t             sts,
  output logic [bfu_pkg::FW-1:0]        res_pos_x,
  output logic [bfu_pkg::FW-1:0]        res_pos_y,
  output logic [bfu_pkg::FW-1:0]        res_vel_x,
  output logic [bfu_pkg::FW-1:0]        res_vel_y
);

  import bfu_pkg::*;

  localparam int AW   = (NUM_BOIDS > 1) ? $clog2(NUM_BOIDS) : 1;
  localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW   = AW + 1;
  localparam int SUMW = 32;
  localparam int AXW  = 35;
  localparam int D2W  = 2 * FW + 3;
  localparam logic signed [AXW:0] VMAX = (AXW+1)'(2**(FW-1) - 1);
  localparam logic signed [AXW:0] VMIN = ~VMAX;

  function automatic logic [9:0] nz10(input logic [9:0] d);
    return (d == '0) ? 10'd1 : d;
  endfunction

  function automatic logic signed [FW-1:0] sat_fw(input logic signed [AXW:0] v);
    if (v > VMAX) begin
      return VMAX[FW-1:0];
    end else if (v < VMIN) begin
      return VMIN[FW-1:0];
    end
    return v[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] wrap_fw(input logic signed [FW:0] p,
                                            input logic [12:0] bound);
    logic [FW-1:0] b;
    b = FW'({bound, 8'b0});
    if (p[FW]) begin
      return b;
    end else if (p[FW-1:0] > b) begin
      return '0;
    end
    return p[FW-1:0];
  endfunction

  // configuration
  logic [9:0]  sep_div, ali_div, coh_div;
  logic [7:0]  max_spd;
  logic [10:0] perc_r, close_r;
  logic [12:0] world_w, world_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_div <= RST_SEP_DIV;
      ali_div <= RST_ALI_DIV;
      coh_div <= RST_COH_DIV;
      max_spd <= RST_MAX_SPD;
      perc_r  <= RST_PERC_R;
      close_r <= RST_CLOSE_R;
      world_w <= RST_WORLD_W;
      world_h <= RST_WORLD_H;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEP_DIV: sep_div <= cfg_wdata[9:0];
        REG_ALI_DIV: ali_div <= cfg_wdata[9:0];
        REG_COH_DIV: coh_div <= cfg_wdata[9:0];
        REG_MAX_SPD: max_spd <= cfg_wdata[7:0];
        REG_PERC_R:  perc_r  <= cfg_wdata[10:0];
        REG_CLOSE_R: close_r <= cfg_wdata[10:0];
        REG_WORLD_W: world_w <= cfg_wdata;
        REG_WORLD_H: world_h <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  logic                 cmd_q;
  logic [IDXW-1:0]      idx_q;
  logic signed [FW-1:0] ld_px, ld_py, ld_vx, ld_vy;
  logic [AW-1:0]        me;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cmd_q <= in_cmd;
      idx_q <= in_index;
      ld_px <= in_pos_x;
      ld_py <= in_pos_y;
      ld_vx <= in_vel_x;
      ld_vy <= in_vel_y;
    end
  end

  assign me = idx_q[AW-1:0];

  // boid table
  logic                 ram_we;
  logic [4*FW-1:0]      ram_wdata, ram_rdata;
  logic [AW-1:0]        ram_raddr;
  logic signed [FW-1:0] rd_px, rd_py, rd_vx, rd_vy;
  logic signed [FW-1:0] new_px, new_py, new_vx, new_vy;

  assign ram_we    = cmd.load_wr | cmd.upd_wr;
  assign ram_wdata = cmd.load_wr ? {ld_vy, ld_vx, ld_py, ld_px}
                                 : {new_vy, new_vx, new_py, new_px};
  assign ram_raddr = cmd.scan_rd ? cmd.scan_k[AW-1:0] : me;
  assign {rd_vy, rd_vx, rd_py, rd_px} = ram_rdata;

  bfu_ram #(.WIDTH(4*FW), .DEPTH(NUM_BOIDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (me),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [GW-1:0] grp_tab [NUM_BOIDS];
  for (genvar g = 0; g < NUM_BOIDS; g++) begin : g_grp
    assign grp_tab[g] = GW'(g % GROUPS);
  end

  // self entry and radii
  logic signed [FW-1:0] self_px, self_py, self_vx, self_vy;
  logic [37:0]          pr2, cr2;
  logic [18:0]          prr, crr;

  assign prr = {perc_r, 8'b0};
  assign crr = {close_r, 8'b0};

  // scan pipeline
  logic                   v1, v2, v3, v4;
  logic [AW-1:0]          k1;
  logic signed [FW:0]     dx2, dy2, dx3, dy3, dx4, dy4;
  logic                   gm2, gm3, gm4;
  logic signed [FW-1:0]   px2, py2, vx2, vy2, px3, py3, vx3, vy3, px4, py4, vx4, vy4;
  logic signed [2*FW+1:0] sqx3, sqy3;
  logic [D2W-1:0]         d24;
  logic                   near4, close4;
  logic signed [SUMW-1:0] sep_x, sep_y, ali_x, ali_y, coh_x, coh_y;
  logic [CW-1:0]          n_close, n_near;

  assign near4  = d24 < D2W'(pr2);
  assign close4 = near4 && (d24 < D2W'(cr2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_rd;
      v2 <= v1 && (k1 != me);
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    k1  <= cmd.scan_k[AW-1:0];
    dx2 <= (FW+1)'(rd_px) - (FW+1)'(self_px);
    dy2 <= (FW+1)'(rd_py) - (FW+1)'(self_py);
    gm2 <= grp_tab[k1] == grp_tab[me];
    px2 <= rd_px;
    py2 <= rd_py;
    vx2 <= rd_vx;
    vy2 <= rd_vy;
    sqx3 <= dx2 * dx2;
    sqy3 <= dy2 * dy2;
    {dx3, dy3, gm3, px3, py3, vx3, vy3} <= {dx2, dy2, gm2, px2, py2, vx2, vy2};
    d24 <= D2W'($unsigned(sqx3)) + D2W'($unsigned(sqy3));
    {dx4, dy4, gm4, px4, py4, vx4, vy4} <= {dx3, dy3, gm3, px3, py3, vx3, vy3};
  end

  always_ff @(posedge clk) begin
    if (cmd.self_cap) begin
      self_px <= rd_px;
      self_py <= rd_py;
      self_vx <= rd_vx;
      self_vy <= rd_vy;
      pr2     <= prr * prr;
      cr2     <= crr * crr;
      sep_x   <= '0;
      sep_y   <= '0;
      ali_x   <= '0;
      ali_y   <= '0;
      coh_x   <= '0;
      coh_y   <= '0;
      n_close <= '0;
      n_near  <= '0;
    end else if (v4) begin
      if (close4) begin
        sep_x   <= sep_x - SUMW'(dx4);
        sep_y   <= sep_y - SUMW'(dy4);
        n_close <= n_close + CW'(1);
      end
      if (near4 && gm4) begin
        ali_x  <= ali_x + SUMW'(vx4);
        ali_y  <= ali_y + SUMW'(vy4);
        coh_x  <= coh_x + SUMW'(px4);
        coh_y  <= coh_y + SUMW'(py4);
        n_near <= n_near + CW'(1);
      end
    end
  end

  // divisions, speed cap, wrap
  logic [DIV_DW-1:0]        sep_d, ali_d, div_den;
  logic signed [DIV_NW-1:0] div_num, quo;
  logic                     div_busy, div_done;
  logic signed [AXW-1:0]    axc, ayc;
  logic signed [FW-1:0]     avg_x, avg_y;
  logic [15:0]              m;
  logic [31:0]              mm;
  logic signed [SQ_SW-1:0]  sq_vx, sq_vy;
  logic signed [DIV_NW-1:0] pm_x, pm_y;
  logic [SQ_SW-1:0]         s_reg;
  logic [SQ_RW-1:0]         len;
  logic                     sqrt_done;

  assign m = {max_spd, 8'b0};

  always_comb begin
    div_num = pm_y;
    div_den = DIV_DW'(len);
    unique case (cmd.div_op)
      OP_SEP_X: begin div_num = DIV_NW'(sep_x); div_den = sep_d; end
      OP_SEP_Y: begin div_num = DIV_NW'(sep_y); div_den = sep_d; end
      OP_ALI_X: begin div_num = DIV_NW'(ali_x) - DIV_NW'(self_vx); div_den = ali_d; end
      OP_ALI_Y: begin div_num = DIV_NW'(ali_y) - DIV_NW'(self_vy); div_den = ali_d; end
      OP_AVG_X: begin div_num = DIV_NW'(coh_x); div_den = DIV_DW'(n_near); end
      OP_AVG_Y: begin div_num = DIV_NW'(coh_y); div_den = DIV_DW'(n_near); end
      OP_COH_X: begin
        div_num = DIV_NW'(avg_x) - DIV_NW'(self_px);
        div_den = DIV_DW'(nz10(coh_div));
      end
      OP_COH_Y: begin
        div_num = DIV_NW'(avg_y) - DIV_NW'(self_py);
        div_den = DIV_DW'(nz10(coh_div));
      end
      OP_CAP_X: begin div_num = pm_x; div_den = DIV_DW'(len); end
      OP_CAP_Y: begin div_num = pm_y; div_den = DIV_DW'(len); end
      default: ;
    endcase
  end

  bfu_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  bfu_sqrt #(.RW(SQ_RW)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .s     (s_reg),
    .done  (sqrt_done),
    .root  (len)
  );

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sep_d <= DIV_DW'(n_close) * DIV_DW'(nz10(sep_div));
      ali_d <= DIV_DW'(n_near) * DIV_DW'(nz10(ali_div));
      axc   <= '0;
      ayc   <= '0;
    end
    if (div_done) begin
      unique case (cmd.div_op)
        OP_SEP_X, OP_ALI_X, OP_COH_X: axc <= axc + AXW'(quo);
        OP_SEP_Y, OP_ALI_Y, OP_COH_Y: ayc <= ayc + AXW'(quo);
        OP_AVG_X: avg_x  <= quo[FW-1:0];
        OP_AVG_Y: avg_y  <= quo[FW-1:0];
        OP_CAP_X: new_vx <= quo[FW-1:0];
        OP_CAP_Y: new_vy <= quo[FW-1:0];
        default: ;
      endcase
    end
    if (cmd.vel_upd) begin
      new_vx <= sat_fw((AXW+1)'(self_vx) + (AXW+1)'(axc));
      new_vy <= sat_fw((AXW+1)'(self_vy) + (AXW+1)'(ayc));
    end
    if (cmd.mul) begin
      sq_vx <= new_vx * new_vx;
      sq_vy <= new_vy * new_vy;
      mm    <= m * m;
      pm_x  <= new_vx * $signed({1'b0, m});
      pm_y  <= new_vy * $signed({1'b0, m});
    end
    if (cmd.cmp) begin
      s_reg <= $unsigned(sq_vx) + $unsigned(sq_vy);
    end
    if (cmd.wrap) begin
      new_px <= wrap_fw((FW+1)'(self_px) + (FW+1)'(new_vx), world_w);
      new_py <= wrap_fw((FW+1)'(self_py) + (FW+1)'(new_vy), world_h);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.res_sel)
        RES_LOAD: {res_vel_y, res_vel_x, res_pos_y, res_pos_x} <= {ld_vy, ld_vx, ld_py, ld_px};
        RES_UPD:  {res_vel_y, res_vel_x, res_pos_y, res_pos_x} <= {new_vy, new_vx, new_py, new_px};
        default:  {res_vel_y, res_vel_x, res_pos_y, res_pos_x} <= '0;
      endcase
    end
  end

  assign sts.is_update = cmd_q == CMD_UPDATE;
  assign sts.in_range  = {1'b0, idx_q} < (IDXW+1)'(NUM_BOIDS);
  assign sts.scan_busy = v1 | v2 | v3 | v4;
  assign sts.any_close = n_close != '0;
  assign sts.any_near  = n_near != '0;
  assign sts.div_busy  = div_busy;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.need_cap  = s_reg > SQ_SW'(mm);

endmodule

// ----- rtl/core/bfu_ctrl.sv -----
module bfu_ctrl #(
  parameter int NUM_BOIDS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bfu_pkg::bfu_sts_t sts,
  output bfu_pkg::bfu_cmd_t cmd
);

  import bfu_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SELF_RD, S_SELF_CAP, S_SCAN, S_DRAIN, S_PREP, S_DIV_GO,
    S_DIV_WAIT, S_VEL, S_MUL, S_CMP, S_CHK, S_SQRT_GO, S_SQRT_WAIT, S_FIN
  } state_t;

  state_t          state;
  div_op_t         op;
  res_sel_t        kind;
  logic [IDXW-1:0] k;
  logic            out_free;
  logic            sep_op, near_op;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;
  assign sep_op   = (op == OP_SEP_X) || (op == OP_SEP_Y);
  assign near_op  = !sep_op && (op != OP_CAP_X) && (op != OP_CAP_Y);

  function automatic div_op_t next_op(input div_op_t o);
    unique case (o)
      OP_SEP_X: return OP_SEP_Y;
      OP_SEP_Y: return OP_ALI_X;
      OP_ALI_X: return OP_ALI_Y;
      OP_ALI_Y: return OP_AVG_X;
      OP_AVG_X: return OP_AVG_Y;
      OP_AVG_Y: return OP_COH_X;
      OP_COH_X: return OP_COH_Y;
      OP_CAP_X: return OP_CAP_Y;
      default:  return OP_CAP_Y;
    endcase
  endfunction

  always_comb begin
    cmd            = '0;
    cmd.scan_k     = k;
    cmd.div_op     = op;
    cmd.res_sel    = kind;
    cmd.cap_in     = (state == S_IDLE) && in_valid;
    cmd.self_rd    = state == S_SELF_RD;
    cmd.self_cap   = state == S_SELF_CAP;
    cmd.scan_rd    = state == S_SCAN;
    cmd.prep       = state == S_PREP;
    cmd.div_start  = (state == S_DIV_GO) && !(sep_op && !sts.any_close)
                     && !(near_op && !sts.any_near);
    cmd.vel_upd    = state == S_VEL;
    cmd.mul        = state == S_MUL;
    cmd.cmp        = state == S_CMP;
    cmd.sqrt_start = state == S_SQRT_GO;
    // op returns to OP_SEP_X only after the capped velocity is in place
    cmd.wrap       = (state == S_CHK) && (!sts.need_cap || (op == OP_SEP_X));
    cmd.out_load   = (state == S_FIN) && out_free;
    cmd.load_wr    = cmd.out_load && (kind == RES_LOAD);
    cmd.upd_wr     = cmd.out_load && (kind == RES_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op        <= OP_SEP_X;
      kind      <= RES_ZERO;
      k         <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!sts.in_range) begin
            kind  <= RES_ZERO;
            state <= S_FIN;
          end else if (!sts.is_update) begin
            kind  <= RES_LOAD;
            state <= S_FIN;
          end else begin
            kind  <= RES_UPD;
            state <= S_SELF_RD;
          end
        end
        S_SELF_RD: state <= S_SELF_CAP;
        S_SELF_CAP: begin
          k     <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (k == IDXW'(NUM_BOIDS - 1)) begin
            state <= S_DRAIN;
          end else begin
            k <= k + IDXW'(1);
          end
        end
        S_DRAIN: begin
          if (!sts.scan_busy) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          op    <= OP_SEP_X;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          priority if (sep_op && !sts.any_close) begin
            op <= OP_ALI_X;
          end else if (near_op && !sts.any_near) begin
            state <= S_VEL;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            priority if (op == OP_COH_Y) begin
              state <= S_VEL;
            end else if (op == OP_CAP_Y) begin
              state <= S_CHK;
              op    <= OP_SEP_X;
            end else begin
              op    <= next_op(op);
              state <= S_DIV_GO;
            end
          end
        end
        S_VEL: state <= S_MUL;
        S_MUL: state <= S_CMP;
        S_CMP: state <= S_CHK;
        S_CHK: begin
          if (sts.need_cap && (op != OP_SEP_X)) begin
            state <= S_SQRT_GO;
          end else begin
            state <= S_FIN;
          end
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sts.sqrt_done) begin
            op    <= OP_CAP_X;
            state <= S_DIV_GO;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !cmd.out_load) |=> !out_valid)
    else $error("result shown twice");
`endif

endmodule

// ----- rtl/core/boid_flocking_update_unit.sv -----
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tuser: command; tdata: index, pos x/y, vel x/y
// m_*      out  tvalid/tready    tdata: new pos x/y, new vel x/y
// cfg_*    in   cfg_we           cfg_addr register index, cfg_wdata value
//
// A load or an out-of-range index goes from decode straight to the result.
// An update scans the table (one read port), then runs up to 8 divisions
// on the shared divider, the velocity update and, when the speed limit
// applies, a square root and two more divisions.
// rst is synchronous; the table is not cleared. A result waiting on m_tready
// holds the finish of the next item only.
module boid_flocking_update_unit #(
  parameter int NUM_BOIDS = bfu_pkg::NUM_BOIDS_DEF,
  parameter int GROUPS    = bfu_pkg::GROUPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bfu_pkg::IN_DW-1:0]    s_tdata,  // index, pos_x, pos_y, vel_x, vel_y, pad
  input  logic [0:0]                   s_tuser,  // command
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bfu_pkg::OUT_DW-1:0]   m_tdata,  // pos_x, pos_y, vel_x, vel_y
  input  logic                         cfg_we,
  input  logic [bfu_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bfu_pkg::CFG_DW-1:0]   cfg_wdata
);

  import bfu_pkg::*;

  bfu_cmd_t      cmd;
  bfu_sts_t      sts;
  logic [FW-1:0] res_pos_x, res_pos_y, res_vel_x, res_vel_y;

  bfu_ctrl #(.NUM_BOIDS(NUM_BOIDS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfu_datapath #(.NUM_BOIDS(NUM_BOIDS), .GROUPS(GROUPS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (s_tuser[0]),
    .in_index  (s_tdata[IDXW-1:0]),
    .in_pos_x  (s_tdata[IDXW +: FW]),
    .in_pos_y  (s_tdata[IDXW+FW +: FW]),
    .in_vel_x  (s_tdata[IDXW+2*FW +: FW]),
    .in_vel_y  (s_tdata[IDXW+3*FW +: FW]),
    .cmd       (cmd),
    .sts       (sts),
    .res_pos_x (res_pos_x),
    .res_pos_y (res_pos_y),
    .res_vel_x (res_vel_x),
    .res_vel_y (res_vel_y)
  );

  assign m_tdata = {res_vel_y, res_vel_x, res_pos_y, res_pos_x};

endmodule
